// ----- rtl/ttc_pkg.sv -----
// Shared types and constants of the text terminal cursor controller.
package ttc_pkg;

  localparam int TEXT_COLUMNS = 53;
  localparam int TEXT_LINES = 32;
  localparam int COL_W = 6;
  localparam int LINE_W = 5;
  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);

  localparam logic [7:0] CODE_BEEP = 8'd7;
  localparam logic [7:0] CODE_BS = 8'd8;
  localparam logic [7:0] CODE_TAB = 8'd9;
  localparam logic [7:0] CODE_NL = 8'd10;
  localparam logic [7:0] CODE_VT = 8'd11;
  localparam logic [7:0] CODE_CLEAR = 8'd12;
  localparam logic [7:0] CODE_PAREN_OPEN = 8'd17;
  localparam logic [7:0] CODE_PAREN_OPEN_HI = 8'd18;
  localparam logic [7:0] CODE_PAREN_CLOSE = 8'd19;
  localparam logic [7:0] CODE_PAREN_CLOSE_HI = 8'd20;
  localparam logic [7:0] CODE_DEL = 8'h7f;
  localparam logic [6:0] PRINT_FIRST = 7'd32;
  localparam logic [6:0] LOW7_DEL = 7'h7f;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_OPEN = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;
  localparam logic [7:0] CURSOR_GLYPH = 8'h5f;
  localparam logic [7:0] HIGHLIGHT_BIT = 8'h80;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_CLEAR_ROW = 2'd1;
  localparam logic [1:0] KIND_CLEAR_ALL = 2'd2;
  localparam logic [1:0] KIND_BEEP = 2'd3;

  typedef enum logic [3:0] {
    OP_BS,
    OP_TAB,
    OP_PAREN,
    OP_DEL,
    OP_PRINT,
    OP_CLEAR,
    OP_NL,
    OP_VT,
    OP_BEEP,
    OP_OTHER
  } op_t;

  typedef struct packed {
    op_t op;
    logic [7:0] ch;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_ACT,
    PH_SCROLL,
    PH_GLYPH
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [LINE_W-1:0] phys_row;
    logic [COL_W-1:0] cell_column;
    logic [7:0] cell_char;
    logic [LINE_W-1:0] view_offset;
    logic last;
  } res_t;

endpackage

// ----- rtl/text_terminal_cursor_controller.sv -----
// Top level of the text terminal cursor controller.
// Each character code pushed in becomes zero to four store operations on the result
// side, one transfer per cycle unless the held result has not been popped: a code
// that only moves the cursor (backspace, tab) yields nothing, a parenthesis yields
// one write, and other codes yield a space write, an optional character write,
// clear-all, beep or row clear, and the cursor write. A four-entry command queue
// lets the input side keep pushing while results wait to be popped.
module text_terminal_cursor_controller import ttc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          char_code,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          kind,
  output logic [LINE_W-1:0]   phys_row,
  output logic [COL_W-1:0]    cell_column,
  output logic [7:0]          cell_char,
  output logic [LINE_W-1:0]   view_offset,
  output logic                last
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  res_t res;

  ttc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .char_code (char_code),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  ttc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .res_out   (res)
  );

  assign kind = res.kind;
  assign phys_row = res.phys_row;
  assign cell_column = res.cell_column;
  assign cell_char = res.cell_char;
  assign view_offset = res.view_offset;
  assign last = res.last;

endmodule

// ----- rtl/ttc_front.sv -----
// Front end: classifies incoming character codes and queues the commands.
module ttc_front import ttc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);

  cmd_t entries [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr;
  logic [CQ_PTR_W-1:0] rd_ptr;
  logic [CQ_PTR_W:0] count;
  cmd_t cls;
  logic push_ok;
  logic pop_ok;

  always_comb begin
    cls.ch = char_code;
    if (char_code == CODE_BS) begin
      cls.op = OP_BS;
    end else if (char_code == CODE_TAB) begin
      cls.op = OP_TAB;
    end else if (char_code >= CODE_PAREN_OPEN && char_code <= CODE_PAREN_CLOSE_HI) begin
      cls.op = OP_PAREN;
      cls.ch = (char_code <= CODE_PAREN_OPEN_HI) ? CHAR_OPEN : CHAR_CLOSE;
      if (char_code == CODE_PAREN_OPEN_HI || char_code == CODE_PAREN_CLOSE_HI) begin
        cls.ch = cls.ch | HIGHLIGHT_BIT;
      end
    end else if (char_code == CODE_DEL) begin
      cls.op = OP_DEL;
    end else if (char_code[6:0] >= PRINT_FIRST) begin
      cls.op = OP_PRINT;
    end else if (char_code == CODE_CLEAR) begin
      cls.op = OP_CLEAR;
    end else if (char_code == CODE_NL) begin
      cls.op = OP_NL;
    end else if (char_code == CODE_VT) begin
      cls.op = OP_VT;
    end else if (char_code == CODE_BEEP) begin
      cls.op = OP_BEEP;
    end else begin
      cls.op = OP_OTHER;
    end
  end

  assign full = (count == (CQ_PTR_W+1)'(CQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd = entries[rd_ptr];
  assign push_ok = push && !full;
  assign pop_ok = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/ttc_back.sv -----
// Back end: carries out queued commands on the cursor state and emits store operations.
module ttc_back import ttc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic empty,
  input  logic pop,
  output res_t res_out
);

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(TEXT_COLUMNS - 1);
  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(TEXT_LINES - 1);
  localparam logic [LINE_W-1:0] VT_LINE = LINE_W'(TEXT_LINES - 3);

  phase_t phase;
  phase_t phase_next;
  logic [LINE_W-1:0] cursor_line;
  logic [LINE_W-1:0] cursor_line_next;
  logic [COL_W-1:0] cursor_column;
  logic [COL_W-1:0] cursor_column_next;
  logic [LINE_W-1:0] scroll_offset;
  logic [LINE_W-1:0] scroll_offset_next;
  logic out_valid;
  res_t out_q;
  res_t res;
  logic emit;
  logic done;
  logic advance;
  logic out_ready;
  logic [LINE_W:0] row_sum;
  logic [LINE_W-1:0] cur_phys;

  assign row_sum = {1'b0, cursor_line} + {1'b0, scroll_offset};
  assign cur_phys = (row_sum >= (LINE_W+1)'(TEXT_LINES))
                    ? LINE_W'(row_sum - (LINE_W+1)'(TEXT_LINES))
                    : LINE_W'(row_sum);

  assign out_ready = !out_valid || pop;
  assign advance = cmd_valid && (!emit || out_ready);
  assign cmd_pop = advance && done;

  always_comb begin
    emit = 1'b0;
    done = 1'b0;
    res.kind = KIND_WRITE;
    res.phys_row = cur_phys;
    res.cell_column = cursor_column;
    res.cell_char = CHAR_SPACE;
    res.view_offset = scroll_offset;
    res.last = 1'b0;
    unique case (phase)
      PH_SPACE: begin
        unique case (cmd.op)
          OP_BS, OP_TAB: begin
            done = 1'b1;
          end
          OP_PAREN: begin
            emit = 1'b1;
            done = 1'b1;
            res.cell_char = cmd.ch;
            res.last = 1'b1;
          end
          default: begin
            emit = 1'b1;
          end
        endcase
      end
      PH_ACT: begin
        emit = 1'b1;
        unique case (cmd.op)
          OP_CLEAR: begin
            res.kind = KIND_CLEAR_ALL;
            res.phys_row = '0;
            res.cell_column = '0;
            res.cell_char = '0;
            res.view_offset = '0;
          end
          OP_BEEP: begin
            res.kind = KIND_BEEP;
            res.phys_row = '0;
            res.cell_column = '0;
            res.cell_char = '0;
          end
          default: begin
            res.cell_char = cmd.ch;
          end
        endcase
      end
      PH_SCROLL: begin
        emit = 1'b1;
        res.kind = KIND_CLEAR_ROW;
        res.phys_row = scroll_offset;
        res.cell_column = '0;
        res.cell_char = '0;
      end
      PH_GLYPH: begin
        emit = 1'b1;
        done = 1'b1;
        res.cell_char = CURSOR_GLYPH;
        res.last = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_comb begin
    phase_next = phase;
    cursor_line_next = cursor_line;
    cursor_column_next = cursor_column;
    scroll_offset_next = scroll_offset;
    if (advance) begin
      unique case (phase)
        PH_SPACE: begin
          phase_next = PH_GLYPH;
          unique case (cmd.op)
            OP_BS, OP_DEL: begin
              if (cursor_column == '0) begin
                if (cursor_line != '0) begin
                  cursor_line_next = cursor_line - 1'b1;
                  cursor_column_next = LAST_COL;
                end
              end else begin
                cursor_column_next = cursor_column - 1'b1;
              end
              if (cmd.op == OP_BS) begin
                phase_next = PH_SPACE;
              end
            end
            OP_TAB: begin
              phase_next = PH_SPACE;
              if (cursor_column >= LAST_COL) begin
                if (cursor_line < LAST_LINE) begin
                  cursor_line_next = cursor_line + 1'b1;
                  cursor_column_next = '0;
                end
              end else begin
                cursor_column_next = cursor_column + 1'b1;
              end
            end
            OP_PAREN: begin
              phase_next = PH_SPACE;
            end
            OP_PRINT, OP_CLEAR, OP_BEEP: begin
              phase_next = PH_ACT;
            end
            OP_NL: begin
              cursor_column_next = '0;
              if (cursor_line >= LAST_LINE) begin
                phase_next = PH_SCROLL;
              end else begin
                cursor_line_next = cursor_line + 1'b1;
              end
            end
            OP_VT: begin
              cursor_column_next = '0;
              scroll_offset_next = '0;
              cursor_line_next = VT_LINE;
            end
            default: begin
              phase_next = PH_GLYPH;
            end
          endcase
        end
        PH_ACT: begin
          phase_next = PH_GLYPH;
          if (cmd.op == OP_CLEAR) begin
            cursor_line_next = '0;
            cursor_column_next = '0;
            scroll_offset_next = '0;
          end else if (cmd.op == OP_PRINT) begin
            if (cursor_column >= LAST_COL) begin
              cursor_column_next = '0;
              if (cursor_line >= LAST_LINE) begin
                phase_next = PH_SCROLL;
              end else begin
                cursor_line_next = cursor_line + 1'b1;
              end
            end else begin
              cursor_column_next = cursor_column + 1'b1;
            end
          end
        end
        PH_SCROLL: begin
          phase_next = PH_GLYPH;
          scroll_offset_next = (scroll_offset == LAST_LINE) ? '0 : scroll_offset + 1'b1;
        end
        PH_GLYPH: begin
          phase_next = PH_SPACE;
        end
        default: begin
          phase_next = PH_SPACE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SPACE;
      cursor_line <= '0;
      cursor_column <= '0;
      scroll_offset <= '0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      cursor_line <= cursor_line_next;
      cursor_column <= cursor_column_next;
      scroll_offset <= scroll_offset_next;
      if (advance && emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_q <= res;
    end
  end

  assign empty = !out_valid;
  assign res_out = out_q;

endmodule
